FILE: src/char_class_range_set_defines.svh
// assertion macros for the character class range set
`ifndef CHAR_CLASS_RANGE_SET_DEFINES_SVH
`define CHAR_CLASS_RANGE_SET_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on every clock edge outside reset
`define CCRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ccrs assertion failed");
// check a property on every clock edge, reset included
`define CCRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ccrs assertion failed");
`else
`define CCRS_ASSERT(lbl, clk, rstn, prop)
`define CCRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/ccrs_pkg.sv
// shared types and constants for the character class range set
`timescale 1ns / 1ps
package ccrs_pkg;

  localparam int CODE_W = 21;
  localparam int TOT_W  = CODE_W + 1;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_TEST  = 3'd2,
    CMD_CASE  = 3'd3,
    CMD_COMP  = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_GETC  = 3'd6,
    CMD_GETR  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_MERGE  = 2'd1,
    PH_AFTER  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CODE_W-1:0] b;
    logic [CODE_W-1:0] e;
  } span_t;

  typedef struct packed {
    logic  valid;
    span_t span;
  } push_t;

  // running state of one pass over the table
  typedef struct packed {
    phase_e            phase;
    logic [CODE_W-1:0] mb;
    logic [CODE_W-1:0] me;
    logic [CODE_W:0]   cur;
    logic              stop;
    logic [CODE_W-1:0] pos;
    logic              hit;
    logic              found;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
  } ctx_t;

endpackage

FILE: src/ccrs_if.sv
// item channels of the character class range set
`timescale 1ns / 1ps
interface ccrs_in_if;
  import ccrs_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [CODE_W-1:0] range_low;
  logic [CODE_W-1:0] range_high;
  logic [CODE_W-1:0] position;
  modport source (output valid, command, range_low, range_high, position, input ready);
  modport sink (input valid, command, range_low, range_high, position, output ready);
endinterface

interface ccrs_out_if;
  import ccrs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              hit;
  logic [CODE_W-1:0] first_char;
  logic [CODE_W-1:0] last_char;
  logic [4:0]        stored_ranges;
  logic [CODE_W-1:0] member_total;
  modport source (output valid, status, hit, first_char, last_char, stored_ranges,
                  member_total, input ready);
  modport sink (input valid, status, hit, first_char, last_char, stored_ranges,
                member_total, output ready);
endinterface

FILE: src/char_class_range_set.sv
// top level: range table sequencer, configuration port and result register
//
//   channel  dir  handshake        carries
//   in_i     in   valid/ready      command, range_low, range_high, position
//   out_o    out  valid/ready      status, hit, first_char, last_char, counts
//   apb      in   psel/penable     universe_low (0x0), universe_high (0x4)
//
// an item reads each stored range in turn (READ, EVAL), with an extra PUSH2 step when a
// delete splits a range or an add merge closes ahead of a stored range, then FIN and DONE
// clear and an add outside the universe go straight to DONE; ready returns with the result
// the new table is built in the other ram bank and taken over by a bank flip
// reset empties the class; the ram needs no clearing
// a waiting result holds the sequencer in its last state until taken
`timescale 1ns / 1ps
`include "char_class_range_set_defines.svh"
module char_class_range_set #(
  parameter int MAX_SPANS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ccrs_in_if.sink          in_i,
  ccrs_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ccrs_pkg::*;

  localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int AW = IW + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_PUSH2 = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CODE_W-1:0] ulo_q, uhi_q, lo, hi;
  logic [CW-1:0]     cnt_q, i_q, dcnt_q;
  logic              bank_q, ovf_q;
  logic [TOT_W-1:0]  total_q, acc_q;
  cmd_e              cmd_q, in_cmd;
  span_t             opnd_q, in_span, elem;
  status_e           stat_q, res_status;
  ctx_t              ctx_q, ctx_nx, ctx_init;
  push_t             pend_q, push0, push1, fin, push_sel;
  logic [CODE_W-1:0] a, z, sa, sz;
  logic              outside, accept, full, ram_we, modify, commit, done_fire;
  logic [TOT_W-1:0]  plen, new_total;
  logic [CW-1:0]     new_cnt;
  logic [2*CODE_W-1:0] rdata;
  logic              out_valid_q;
  logic [1:0]        o_status_q;
  logic              o_hit_q;
  logic [CODE_W-1:0] o_first_q, o_last_q, o_total_q;
  logic [4:0]        o_ranges_q;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2]) prdata[CODE_W-1:0] = uhi_q;
    else          prdata[CODE_W-1:0] = ulo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ulo_q <= '0;
      uhi_q <= CODE_W'(255);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) uhi_q <= pwdata[CODE_W-1:0];
      else          ulo_q <= pwdata[CODE_W-1:0];
    end
  end

  // operand normalization at accept
  always_comb begin
    lo = (ulo_q > uhi_q) ? uhi_q : ulo_q;
    hi = (ulo_q > uhi_q) ? ulo_q : uhi_q;
    in_cmd = cmd_e'(in_i.command);
    a  = in_i.range_low;
    z  = in_i.range_high;
    sa = (a > z) ? z : a;
    sz = (a > z) ? a : z;
    outside = (sa > hi) || (sz < lo);
    in_span.b = sa;
    in_span.e = sz;
    if (in_cmd == CMD_ADD) begin
      if (sa < lo) in_span.b = lo;
      if (sz > hi) in_span.e = hi;
    end else if (in_cmd == CMD_CASE) begin
      in_span.b = a;
      in_span.e = a;
    end
    ctx_init       = '0;
    ctx_init.phase = PH_BEFORE;
    ctx_init.mb    = in_span.b;
    ctx_init.me    = in_span.e;
    ctx_init.cur   = {1'b0, lo};
    ctx_init.pos   = in_i.position;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  ccrs_span_unit u_unit (
    .cmd_i       (cmd_q),
    .opnd_i      (opnd_q),
    .hi_i        (hi),
    .elem_i      (elem),
    .idx_match_i (CODE_W'(i_q) == ctx_q.pos),
    .ctx_i       (ctx_q),
    .ctx_o       (ctx_nx),
    .push0_o     (push0),
    .push1_o     (push1),
    .fin_o       (fin)
  );

  // new ranges go into the spare bank, at most one per cycle, until it is full
  always_comb begin
    push_sel = '0;
    unique case (state_q)
      S_EVAL:  push_sel = push0;
      S_PUSH2: push_sel = pend_q;
      S_FIN:   push_sel = fin;
      default: push_sel = '0;
    endcase
    full   = (dcnt_q == CW'(MAX_SPANS));
    ram_we = push_sel.valid && !full;
    plen   = {1'b0, push_sel.span.e} - {1'b0, push_sel.span.b} + 1'b1;
  end

  ccrs_ram #(
    .WIDTH (2 * CODE_W),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({~bank_q, dcnt_q[IW-1:0]}),
    .wdata_i (push_sel.span),
    .raddr_i ({bank_q, i_q[IW-1:0]}),
    .rdata_o (rdata)
  );
  assign elem = span_t'(rdata);

  // result forming
  always_comb begin
    done_fire = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
    modify    = (cmd_q == CMD_ADD) || (cmd_q == CMD_DEL) || (cmd_q == CMD_COMP);
    commit    = modify && (stat_q == ST_DONE) && !ovf_q;
    if (cmd_q == CMD_CLEAR) begin
      new_cnt   = '0;
      new_total = '0;
    end else if (commit) begin
      new_cnt   = dcnt_q;
      new_total = acc_q;
    end else begin
      new_cnt   = cnt_q;
      new_total = total_q;
    end
    priority if (stat_q == ST_OUTSIDE) res_status = ST_OUTSIDE;
    else if (modify && ovf_q) res_status = ST_FULL;
    else if ((cmd_q == CMD_GETC || cmd_q == CMD_GETR) && !ctx_q.found)
      res_status = ST_NOTFOUND;
    else res_status = ST_DONE;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_cmd == CMD_ADD && outside) || in_cmd == CMD_CLEAR) state_d = S_DONE;
          else state_d = S_READ;
        end
      end
      S_READ:  state_d = (i_q < cnt_q) ? S_EVAL : S_FIN;
      S_EVAL:  state_d = push1.valid ? S_PUSH2 : S_READ;
      S_PUSH2: state_d = S_READ;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (done_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      bank_q      <= 1'b0;
      i_q         <= '0;
      dcnt_q      <= '0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        i_q    <= '0;
        dcnt_q <= '0;
        ovf_q  <= 1'b0;
        acc_q  <= '0;
      end
      if ((state_q == S_EVAL && !push1.valid) || state_q == S_PUSH2) begin
        i_q <= i_q + 1'b1;
      end
      if (push_sel.valid) begin
        acc_q <= acc_q + plen;
        if (full) ovf_q  <= 1'b1;
        else      dcnt_q <= dcnt_q + 1'b1;
      end
      if (done_fire) begin
        cnt_q   <= new_cnt;
        total_q <= new_total;
        if (commit) bank_q <= ~bank_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      opnd_q <= in_span;
      ctx_q  <= ctx_init;
      stat_q <= (in_cmd == CMD_ADD && outside) ? ST_OUTSIDE : ST_DONE;
    end
    if (state_q == S_EVAL) begin
      ctx_q  <= ctx_nx;
      pend_q <= push1;
    end
    if (done_fire) begin
      o_status_q <= res_status;
      o_hit_q    <= ctx_q.hit;
      o_first_q  <= ctx_q.first;
      o_last_q   <= ctx_q.last;
      o_ranges_q <= 5'(new_cnt);
      o_total_q  <= new_total[CODE_W] ? {CODE_W{1'b1}} : new_total[CODE_W-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = o_status_q;
  assign out_o.hit           = o_hit_q;
  assign out_o.first_char    = o_first_q;
  assign out_o.last_char     = o_last_q;
  assign out_o.stored_ranges = o_ranges_q;
  assign out_o.member_total  = o_total_q;

  `CCRS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(MAX_SPANS))
  `CCRS_ASSERT(a_dcnt_bound, clk_i, rst_ni, dcnt_q <= CW'(MAX_SPANS))
  `CCRS_ASSERT(a_ovf_full, clk_i, rst_ni, ovf_q |-> dcnt_q == CW'(MAX_SPANS))
  `CCRS_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> state_q != S_IDLE)
  `CCRS_ASSERT(a_write_state, clk_i, rst_ni, ram_we |-> (state_q == S_EVAL || state_q == S_PUSH2 || state_q == S_FIN))
endmodule

FILE: src/ccrs_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module ccrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/ccrs_span_unit.sv
// per-range evaluation step shared by all commands
`timescale 1ns / 1ps
module ccrs_span_unit (
  input  ccrs_pkg::cmd_e             cmd_i,
  input  ccrs_pkg::span_t            opnd_i,
  input  logic [ccrs_pkg::CODE_W-1:0] hi_i,
  input  ccrs_pkg::span_t            elem_i,
  input  logic                       idx_match_i,
  input  ccrs_pkg::ctx_t             ctx_i,
  output ccrs_pkg::ctx_t             ctx_o,
  output ccrs_pkg::push_t            push0_o,
  output ccrs_pkg::push_t            push1_o,
  output ccrs_pkg::push_t            fin_o
);
  import ccrs_pkg::*;

  logic [CODE_W:0]   eb, ee, ob, oe, len;
  logic [CODE_W-1:0] alt;
  logic              letter, cov_a, cov_alt;

  always_comb begin
    eb  = {1'b0, elem_i.b};
    ee  = {1'b0, elem_i.e};
    ob  = {1'b0, opnd_i.b};
    oe  = {1'b0, opnd_i.e};
    len = ee - eb + 1'b1;
    alt = opnd_i.b ^ CODE_W'(32);
    letter = (opnd_i.b >= CODE_W'(65) && opnd_i.b <= CODE_W'(90)) ||
             (opnd_i.b >= CODE_W'(97) && opnd_i.b <= CODE_W'(122));
    cov_a   = (opnd_i.b >= elem_i.b) && (opnd_i.b <= elem_i.e);
    cov_alt = (alt >= elem_i.b) && (alt <= elem_i.e);
    ctx_o   = ctx_i;
    push0_o = '0;
    push1_o = '0;
    fin_o   = '0;
    unique case (cmd_i)
      CMD_ADD: begin
        if (ctx_i.phase != PH_AFTER) begin
          fin_o.valid  = 1'b1;
          fin_o.span.b = ctx_i.mb;
          fin_o.span.e = ctx_i.me;
        end
        if (ctx_i.phase == PH_AFTER ||
            (ctx_i.phase == PH_BEFORE && ee + 1'b1 < ob)) begin
          push0_o.valid = 1'b1;
          push0_o.span  = elem_i;
        end else if (eb <= {1'b0, ctx_i.me} + 1'b1) begin
          ctx_o.phase = PH_MERGE;
          if (elem_i.b < ctx_i.mb) ctx_o.mb = elem_i.b;
          if (elem_i.e > ctx_i.me) ctx_o.me = elem_i.e;
        end else begin
          // merged range closes, then the stored one follows
          push0_o.valid  = 1'b1;
          push0_o.span.b = ctx_i.mb;
          push0_o.span.e = ctx_i.me;
          push1_o.valid  = 1'b1;
          push1_o.span   = elem_i;
          ctx_o.phase    = PH_AFTER;
        end
      end
      CMD_DEL: begin
        if (ee < ob || eb > oe) begin
          push0_o.valid = 1'b1;
          push0_o.span  = elem_i;
        end else begin
          if (eb < ob) begin
            push0_o.valid  = 1'b1;
            push0_o.span.b = elem_i.b;
            push0_o.span.e = opnd_i.b - 1'b1;
          end
          if (ee > oe) begin
            push1_o.valid  = 1'b1;
            push1_o.span.b = opnd_i.e + 1'b1;
            push1_o.span.e = elem_i.e;
          end
        end
      end
      CMD_TEST: begin
        if (opnd_i.b >= elem_i.b && opnd_i.e <= elem_i.e) ctx_o.hit = 1'b1;
      end
      CMD_CASE: begin
        if (cov_a || (letter && cov_alt)) ctx_o.hit = 1'b1;
      end
      CMD_COMP: begin
        if (ctx_i.cur <= {1'b0, hi_i}) begin
          fin_o.valid  = 1'b1;
          fin_o.span.b = ctx_i.cur[CODE_W-1:0];
          fin_o.span.e = hi_i;
        end
        if (!ctx_i.stop && ee >= ctx_i.cur) begin
          if (elem_i.b > hi_i) begin
            ctx_o.stop = 1'b1;
          end else begin
            if (eb > ctx_i.cur) begin
              push0_o.valid  = 1'b1;
              push0_o.span.b = ctx_i.cur[CODE_W-1:0];
              push0_o.span.e = elem_i.b - 1'b1;
            end
            ctx_o.cur = ee + 1'b1;
          end
        end
      end
      CMD_GETC: begin
        if (!ctx_i.found) begin
          if ({1'b0, ctx_i.pos} < len) begin
            ctx_o.found = 1'b1;
            ctx_o.first = elem_i.b + ctx_i.pos;
            ctx_o.last  = elem_i.b + ctx_i.pos;
          end else begin
            ctx_o.pos = ctx_i.pos - len[CODE_W-1:0];
          end
        end
      end
      CMD_GETR: begin
        if (!ctx_i.found && idx_match_i) begin
          ctx_o.found = 1'b1;
          ctx_o.first = elem_i.b;
          ctx_o.last  = elem_i.e;
        end
      end
      CMD_CLEAR: begin
        ctx_o = ctx_i;
      end
      default: begin
        ctx_o = ctx_i;
      end
    endcase
  end
endmodule

FILE: sim/char_class_range_set_test.sv
// self-checking testbench for the character class range set
`timescale 1ns / 1ps
module char_class_range_set_test;
  import ccrs_pkg::*;

  localparam int SPAN_CAP = 16;
  localparam logic [20:0] CODE_MAX = 21'h1FFFFF;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [20:0] first_char;
    logic [20:0] last_char;
    logic [4:0]  stored_ranges;
    logic [20:0] member_total;
  } verdict_t;

  // scoreboard: a shadow of the range table and the verdicts still owed
  class class_shadow;
    logic [20:0] lo_q[$];
    logic [20:0] hi_q[$];
    logic [20:0] uni_lo;
    logic [20:0] uni_hi;
    verdict_t owed[$];
    int errors;
    int checked;

    function void reset_state();
      lo_q.delete();
      hi_q.delete();
      uni_lo = 21'd0;
      uni_hi = 21'd255;
      owed.delete();
      errors = 0;
      checked = 0;
    endfunction

    function bit covers(logic [20:0] b, logic [20:0] e);
      foreach (lo_q[i]) if (b >= lo_q[i] && e <= hi_q[i]) return 1'b1;
      return 1'b0;
    endfunction

    // commit a candidate table unless it overflows
    function status_e commit(logic [20:0] nb[$], logic [20:0] ne[$]);
      if (nb.size() > SPAN_CAP) return ST_FULL;
      lo_q = nb;
      hi_q = ne;
      return ST_DONE;
    endfunction

    function void note_command(cmd_e cmd, logic [20:0] a0, logic [20:0] z0,
                               logic [20:0] pos0);
      logic [20:0] nb[$];
      logic [20:0] ne[$];
      logic [20:0] a, z, lo, hi, b, e, c;
      longint cur, pos, len, tot;
      int i;
      verdict_t v;
      v = '0;
      lo = uni_lo; hi = uni_hi;
      if (lo > hi) begin lo = uni_hi; hi = uni_lo; end
      a = a0; z = z0;
      if (a > z) begin a = z0; z = a0; end
      pos = longint'(pos0);
      v.status = ST_DONE;
      case (cmd)
        CMD_ADD: begin
          if (a > hi || z < lo) v.status = ST_OUTSIDE;
          else begin
            b = (a < lo) ? lo : a;
            e = (z > hi) ? hi : z;
            i = 0;
            while (i < lo_q.size() && longint'(hi_q[i]) + 1 < longint'(b)) begin
              nb.push_back(lo_q[i]); ne.push_back(hi_q[i]); i++;
            end
            while (i < lo_q.size() && longint'(lo_q[i]) <= longint'(e) + 1) begin
              if (lo_q[i] < b) b = lo_q[i];
              if (hi_q[i] > e) e = hi_q[i];
              i++;
            end
            nb.push_back(b); ne.push_back(e);
            for (; i < lo_q.size(); i++) begin
              nb.push_back(lo_q[i]); ne.push_back(hi_q[i]);
            end
            v.status = commit(nb, ne);
          end
        end
        CMD_DEL: begin
          foreach (lo_q[k]) begin
            if (hi_q[k] < a || lo_q[k] > z) begin
              nb.push_back(lo_q[k]); ne.push_back(hi_q[k]);
            end else begin
              if (lo_q[k] < a) begin nb.push_back(lo_q[k]); ne.push_back(a - 21'd1); end
              if (hi_q[k] > z) begin nb.push_back(z + 21'd1); ne.push_back(hi_q[k]); end
            end
          end
          v.status = commit(nb, ne);
        end
        CMD_TEST: v.hit = covers(a, z);
        CMD_CASE: begin
          c = a0;
          if (covers(c, c)) v.hit = 1'b1;
          else if ((c >= 21'd65 && c <= 21'd90) || (c >= 21'd97 && c <= 21'd122))
            v.hit = covers(c ^ 21'h20, c ^ 21'h20);
        end
        CMD_COMP: begin
          cur = longint'(lo);
          foreach (lo_q[k]) begin
            if (longint'(hi_q[k]) < cur) continue;
            if (lo_q[k] > hi) break;
            if (longint'(lo_q[k]) > cur) begin
              nb.push_back(cur[20:0]); ne.push_back(lo_q[k] - 21'd1);
            end
            cur = longint'(hi_q[k]) + 1;
          end
          if (cur <= longint'(hi)) begin nb.push_back(cur[20:0]); ne.push_back(hi); end
          v.status = commit(nb, ne);
        end
        CMD_CLEAR: begin lo_q.delete(); hi_q.delete(); end
        CMD_GETC: begin
          v.status = ST_NOTFOUND;
          foreach (lo_q[k]) begin
            len = longint'(hi_q[k]) - longint'(lo_q[k]) + 1;
            if (pos < len) begin
              v.first_char = lo_q[k] + pos[20:0];
              v.last_char = v.first_char;
              v.status = ST_DONE;
              break;
            end
            pos -= len;
          end
        end
        default: begin
          if (pos < lo_q.size()) begin
            v.first_char = lo_q[pos];
            v.last_char = hi_q[pos];
          end else v.status = ST_NOTFOUND;
        end
      endcase
      tot = 0;
      foreach (lo_q[k]) tot += longint'(hi_q[k]) - longint'(lo_q[k]) + 1;
      if (tot > longint'(CODE_MAX)) tot = longint'(CODE_MAX);
      v.stored_ranges = 5'(lo_q.size());
      v.member_total = tot[20:0];
      owed.push_back(v);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 30)
        $display("mismatch on result %0d: %s got %0h want %0h", checked, what, got, want);
    endtask

    task check_verdict(verdict_t got);
      verdict_t w;
      if (owed.size() == 0) begin
        errors++;
        $display("unexpected result %0d", checked);
        return;
      end
      w = owed.pop_front();
      if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
      if (got.hit !== w.hit) report("hit", 32'(got.hit), 32'(w.hit));
      if (got.first_char !== w.first_char)
        report("first_char", 32'(got.first_char), 32'(w.first_char));
      if (got.last_char !== w.last_char)
        report("last_char", 32'(got.last_char), 32'(w.last_char));
      if (got.stored_ranges !== w.stored_ranges)
        report("stored_ranges", 32'(got.stored_ranges), 32'(w.stored_ranges));
      if (got.member_total !== w.member_total)
        report("member_total", 32'(got.member_total), 32'(w.member_total));
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ccrs_in_if  cmd_ch ();
  ccrs_out_if res_ch ();

  char_class_range_set dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch.sink), .out_o(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  class_shadow shadow = new();
  int stall_cycles = 0;
  int sent = 0;
  bit sink_quiet = 1'b0;
  int cmd_seen[8];

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.range_low = '0;
    cmd_ch.range_high = '0;
    cmd_ch.position = '0;
    res_ch.ready = 1'b0;
  end

  // result side: random stalls per item, check at the accepting edge
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = sink_quiet ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      shadow.check_verdict({res_ch.status, res_ch.hit, res_ch.first_char,
                            res_ch.last_char, res_ch.stored_ranges, res_ch.member_total});
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_ni)
      stall_cycles <= 0;
    else if (shadow.owed.size() != 0 || cmd_ch.valid) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout waiting for a handshake");
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_command(cmd_e cmd, logic [20:0] a, logic [20:0] z, logic [20:0] p,
                              bit gaps = 1'b1);
    int w;
    w = gaps ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) w = 0;
    repeat (w) @(posedge clk_i);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.range_low <= a;
    cmd_ch.range_high <= z;
    cmd_ch.position <= p;
    do @(posedge clk_i); while (!cmd_ch.ready);
    shadow.note_command(cmd, a, z, p);
    cmd_seen[cmd]++;
    sent++;
    cmd_ch.valid <= 1'b0;
    // the block is busy on the cycle after an accept anyway
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (shadow.owed.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [20:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {11'($urandom_range(0, 2047)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) shadow.uni_lo = value;
    else shadow.uni_hi = value;
    @(posedge clk_i);
  endtask

  task automatic set_universe(logic [20:0] lo, logic [20:0] hi);
    drain();
    write_reg(3'd0, lo);
    write_reg(3'd4, hi);
  endtask

  // draws a code near the universe most of the time, anywhere or the top code otherwise
  function automatic logic [20:0] pick_code(logic [20:0] lo, logic [20:0] hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 21'($urandom_range(0, 21'h1FFFFF));
    if (r == 1) return (r[0]) ? 21'h1FFFFF : 21'd0;
    if (hi >= lo) return 21'(lo + $urandom_range(0, (hi - lo > 300) ? 300 : hi - lo) +
                         ((hi - lo > 300 && $urandom_range(0, 1)) ?
                          $urandom_range(0, hi - lo - 300) : 0));
    return 21'(hi + $urandom_range(0, lo - hi));
  endfunction

  task automatic random_phase(int n, logic [20:0] lo, logic [20:0] hi);
    cmd_e c;
    logic [20:0] a, z;
    for (int k = 0; k < n; k++) begin
      c = cmd_e'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) c = CMD_ADD;
      if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) c = CMD_TEST;
      a = pick_code(lo, hi);
      z = ($urandom_range(0, 2) == 0) ? 21'(a + $urandom_range(0, 3)) : pick_code(lo, hi);
      if (c == CMD_CASE && $urandom_range(0, 1)) a = 21'($urandom_range(60, 125));
      send_command(c, a, z, (c == CMD_GETR) ? 21'($urandom_range(0, 18)) :
                   ($urandom_range(0, 4) == 0 ? 21'($urandom_range(0, 21'h1FFFFF)) :
                    21'($urandom_range(0, 400))));
    end
  endtask

  initial begin
    shadow.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command, reversed ends, outside universe, case flip
    send_command(CMD_GETC, 0, 0, 0);
    send_command(CMD_GETR, 0, 0, 0);
    send_command(CMD_ADD, 21'd90, 21'd65, 0);
    send_command(CMD_CASE, 21'd97, 0, 0);
    send_command(CMD_CASE, 21'd122, 0, 0);
    send_command(CMD_CASE, 21'd64, 0, 0);
    send_command(CMD_ADD, 21'h1FFFFF, 21'd300, 0);
    send_command(CMD_ADD, 21'd200, 21'h1FFFFF, 0);
    send_command(CMD_ADD, 21'd91, 21'd91, 0);
    send_command(CMD_TEST, 21'd91, 21'd65, 0);
    send_command(CMD_DEL, 21'd80, 21'd70, 0);
    send_command(CMD_GETC, 0, 0, 21'd15);
    send_command(CMD_GETR, 0, 0, 21'd1);
    send_command(CMD_GETR, 0, 0, 21'h1FFFFF);
    send_command(CMD_COMP, 0, 0, 0);
    send_command(CMD_COMP, 0, 0, 0);
    for (int k = 0; k < 18; k++) send_command(CMD_ADD, 21'(k * 4), 21'(k * 4), 0, 1'b0);
    send_command(CMD_COMP, 0, 0, 0);
    send_command(CMD_DEL, 21'd2, 21'd2, 0);
    send_command(CMD_DEL, 0, 21'h1FFFFF, 0);
    send_command(CMD_CLEAR, 0, 0, 0);

    // reversed universe, then up to 0x10FFFF and the top of the code space
    set_universe(21'd255, 21'd0);
    random_phase(80, 0, 255);
    set_universe(21'd0, 21'h10FFFF);
    send_command(CMD_ADD, 0, 21'h10FFFF, 0);
    send_command(CMD_GETC, 0, 0, 21'h10FFFF);
    send_command(CMD_ADD, 21'h1FFFFF, 21'h1FFFFF, 0);
    random_phase(150, 0, 21'h10FFFF);
    set_universe(21'h1FFFF0, 21'h1FFFFF);
    send_command(CMD_COMP, 0, 0, 0);
    random_phase(80, 21'h1FFFF0, 21'h1FFFFF);

    // back to back with the result side held quiet
    sink_quiet = 1'b1;
    set_universe(21'd40, 21'd130);
    for (int k = 0; k < 60; k++)
      send_command(cmd_e'($urandom_range(0, 7)), 21'($urandom_range(30, 140)),
                   21'($urandom_range(30, 140)), 21'($urandom_range(0, 20)), 1'b0);
    sink_quiet = 1'b0;
    set_universe(21'd1000, 21'd1000);
    random_phase(60, 21'd990, 21'd1010);
    set_universe(21'd0, 21'd255);
    random_phase(250, 0, 255);

    drain();
    $display("sent %0d commands over six universe settings, %0d results checked",
             sent, shadow.checked);
    $display("per command: add %0d del %0d test %0d case %0d comp %0d clear %0d getc %0d getr %0d",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4], cmd_seen[5],
             cmd_seen[6], cmd_seen[7]);
    if (shadow.errors == 0 && shadow.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/ccrs_pkg.sv
src/ccrs_if.sv
src/ccrs_ram.sv
src/ccrs_span_unit.sv
src/char_class_range_set.sv
sim/char_class_range_set_test.sv
